// ===== design/fau_pkg.sv =====
// Shared types and constants for the fraction arithmetic unit.
// Depends on nothing; fau_reduce and the top level use it by scoped names.
package fau_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_DIV = 2'd2,
      OP_CMP = 2'd3
   } op_type;

   localparam int NUM_W  = 33;
   localparam int DEN_W  = 32;
   localparam int RSP_DW = ((NUM_W + DEN_W + 7) / 8) * 8;

   typedef logic [NUM_W-1:0] res_num_type;
   typedef logic [DEN_W-1:0] res_den_type;

   typedef struct packed {
      logic start;
   } red_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } red_stat_type;

endpackage

// ===== design/fau_mul.sv =====
// Registered operand multiplier for the fraction arithmetic unit.
// Depends on nothing; the product is registered and appears in the cycle after the operands.
module fau_mul #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                         clock,
   input  logic [OPERAND_WIDTH-1:0]     a,
   input  logic [OPERAND_WIDTH-1:0]     b,
   output logic [2*OPERAND_WIDTH-1:0]   p
);

   logic [2*OPERAND_WIDTH-1:0] p_ff;
   logic [2*OPERAND_WIDTH-1:0] p_in;

   assign p_in = {{OPERAND_WIDTH{1'b0}}, a} * {{OPERAND_WIDTH{1'b0}}, b};
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// ===== design/fau_reduce.sv =====
// Fraction reducer: binary GCD, then two restoring divisions by the GCD,
// all on one shared subtract/compare unit. Depends on fau_pkg.
module fau_reduce #(
   parameter int VALUE_WIDTH = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fau_pkg::red_ctrl_type      ctrl,
   input  logic [VALUE_WIDTH-1:0]     num,
   input  logic [VALUE_WIDTH-1:0]     den,
   output fau_pkg::red_stat_type      stat,
   output logic [VALUE_WIDTH-1:0]     red_num,
   output logic [VALUE_WIDTH-1:0]     red_den
);

   localparam int VW = VALUE_WIDTH;
   localparam int KW = $clog2(VW);

   typedef enum logic [5:0] {
      RS_IDLE  = 6'b000001,
      RS_GCD   = 6'b000010,
      RS_SHIFT = 6'b000100,
      RS_DIVN  = 6'b001000,
      RS_DIVD  = 6'b010000,
      RS_DONE  = 6'b100000
   } rs_state_type;

   rs_state_type  state_ff, state_in;
   logic [VW-1:0] x_ff, x_in;
   logic [VW-1:0] y_ff, y_in;
   logic [VW-1:0] g_ff, g_in;
   logic [VW-1:0] n_ff, n_in;
   logic [VW-1:0] d_ff, d_in;
   logic [VW-1:0] qd_ff, qd_in;
   logic [VW-1:0] r_ff, r_in;
   logic [VW-1:0] on_ff, on_in;
   logic [VW-1:0] od_ff, od_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] cnt_ff, cnt_in;

   logic [VW:0]   sub_a;
   logic [VW:0]   sub_b;
   logic [VW+1:0] sub_full;
   logic [VW:0]   diff;
   logic          ge;
   logic [VW:0]   rem_sh;
   logic [VW-1:0] quo_next;
   logic [VW-1:0] rem_next;
   logic          div_mode;

   // shared subtract/compare unit
   assign div_mode = (state_ff == RS_DIVN) || (state_ff == RS_DIVD);
   assign rem_sh   = {r_ff, qd_ff[VW-1]};
   assign sub_a    = div_mode ? rem_sh : {1'b0, x_ff};
   assign sub_b    = div_mode ? {1'b0, g_ff} : {1'b0, y_ff};
   assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge       = !sub_full[VW+1];
   assign diff     = sub_full[VW:0];
   assign quo_next = {qd_ff[VW-2:0], ge};
   assign rem_next = ge ? diff[VW-1:0] : rem_sh[VW-1:0];

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      g_in     = g_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      qd_in    = qd_ff;
      r_in     = r_ff;
      on_in    = on_ff;
      od_in    = od_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         RS_IDLE: begin
            if (ctrl.start) begin
               x_in     = num;
               y_in     = den;
               n_in     = num;
               d_in     = den;
               k_in     = '0;
               state_in = RS_GCD;
            end
         end
         RS_GCD: begin
            if (x_ff == '0) begin
               g_in     = y_ff;
               state_in = RS_SHIFT;
            end else if (y_ff == '0) begin
               g_in     = x_ff;
               state_in = RS_SHIFT;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (ge) begin
               x_in = diff[VW:1];
            end else begin
               x_in = y_ff;
               y_in = x_ff;
            end
         end
         RS_SHIFT: begin
            if (k_ff != '0) begin
               g_in = g_ff << 1;
               k_in = k_ff - 1'b1;
            end else if (g_ff == '0) begin
               on_in    = n_ff;
               od_in    = d_ff;
               state_in = RS_DONE;
            end else begin
               qd_in    = n_ff;
               r_in     = '0;
               cnt_in   = KW'(VW - 1);
               state_in = RS_DIVN;
            end
         end
         RS_DIVN: begin
            qd_in  = quo_next;
            r_in   = rem_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               on_in    = quo_next;
               qd_in    = d_ff;
               r_in     = '0;
               cnt_in   = KW'(VW - 1);
               state_in = RS_DIVD;
            end
         end
         RS_DIVD: begin
            qd_in  = quo_next;
            r_in   = rem_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               od_in    = quo_next;
               state_in = RS_DONE;
            end
         end
         RS_DONE: begin
            state_in = RS_IDLE;
         end
         default: begin
            state_in = RS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      g_ff   <= g_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      qd_ff  <= qd_in;
      r_ff   <= r_in;
      on_ff  <= on_in;
      od_ff  <= od_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = (state_ff != RS_IDLE);
   assign stat.done = (state_ff == RS_DONE);
   assign red_num   = on_ff;
   assign red_den   = od_ff;

endmodule

// ===== design/fraction_arithmetic_unit.sv =====
// Fraction arithmetic unit top level: sequencer, operand multiplier, reducer
// and result register. Depends on fau_pkg, fau_mul and fau_reduce.
//
// Usage:
//   req channel: tuser carries the opcode (add, multiply, divide a by b,
//   compare); tdata carries num_a, den_a, num_b, den_b, OPERAND_WIDTH bits
//   each. One word is taken at a time; req_tready is high only while the
//   sequencer is idle.
//   rsp channel: tdata carries the reduced numerator (33 bits) and the
//   reduced denominator (32 bits); tuser carries the equality flag of compare.
//   From accept to result valid, multiply and divide pass the multiplier
//   states MUL0 to MUL2, add also MUL3; then the reducer runs a binary GCD
//   (halving, subtracting or swapping until one value is zero), shifts to
//   restore common factors of two, and does two restoring divisions of
//   2*OPERAND_WIDTH+1 quotient bits each on the same subtract unit. Compare
//   reduces a, then b. The next word can be taken in the cycle after the
//   result loads. Reset clears the sequencer, the reducer and the result
//   valid. A stalled receiver holds the result register; the next request
//   is still taken and worked on, and waits for the register.
module fraction_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // num_a, den_a, num_b, den_b, zero fill
   input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]       req_tdata,
   // opcode
   input  logic [1:0]                                 req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // res_num, res_den, zero fill
   output logic [fau_pkg::RSP_DW-1:0]                 rsp_tdata,
   // equal
   output logic                                       rsp_tuser
);

   localparam int W  = OPERAND_WIDTH;
   localparam int VW = 2 * W + 1;
   localparam int PAD_W = fau_pkg::RSP_DW - fau_pkg::NUM_W - fau_pkg::DEN_W;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_MUL0      = 10'b0000000010,
      ST_MUL1      = 10'b0000000100,
      ST_MUL2      = 10'b0000001000,
      ST_MUL3      = 10'b0000010000,
      ST_REDA_GO   = 10'b0000100000,
      ST_REDA_WAIT = 10'b0001000000,
      ST_REDB_GO   = 10'b0010000000,
      ST_REDB_WAIT = 10'b0100000000,
      ST_OUT       = 10'b1000000000
   } st_type;

   st_type                state_ff, state_in;
   fau_pkg::op_type       op_ff, op_in;
   logic [W-1:0]          na_ff, na_in;
   logic [W-1:0]          da_ff, da_in;
   logic [W-1:0]          nb_ff, nb_in;
   logic [W-1:0]          db_ff, db_in;
   logic [VW-1:0]         rn_ff, rn_in;
   logic [VW-1:0]         rd_ff, rd_in;
   logic [VW-1:0]         bn_ff, bn_in;
   logic [VW-1:0]         bd_ff, bd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fau_pkg::res_num_type  rsp_num_ff, rsp_num_in;
   fau_pkg::res_den_type  rsp_den_ff, rsp_den_in;
   logic                  rsp_eq_ff, rsp_eq_in;

   logic                  req_accept;
   logic                  out_load;
   logic [W-1:0]          mul_a;
   logic [W-1:0]          mul_b;
   logic [2*W-1:0]        mul_p;
   logic [VW-1:0]         mul_p_ext;
   logic [VW-1:0]         red_num_in;
   logic [VW-1:0]         red_den_in;
   logic [VW-1:0]         red_num_out;
   logic [VW-1:0]         red_den_out;
   fau_pkg::red_ctrl_type red_ctrl;
   fau_pkg::red_stat_type red_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign mul_p_ext  = {1'b0, mul_p};

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_MUL0: begin
            mul_a = na_ff;
            mul_b = (op_ff == fau_pkg::OP_MUL) ? nb_ff : db_ff;
         end
         ST_MUL1: begin
            mul_a = (op_ff == fau_pkg::OP_ADD) ? nb_ff : da_ff;
            if (op_ff == fau_pkg::OP_ADD) begin
               mul_b = da_ff;
            end else if (op_ff == fau_pkg::OP_MUL) begin
               mul_b = db_ff;
            end else begin
               mul_b = nb_ff;
            end
         end
         default: begin
            mul_a = da_ff;
            mul_b = db_ff;
         end
      endcase
   end

   fau_mul #(
      .OPERAND_WIDTH(W)
   ) u_mul (
      .clock(clock),
      .a    (mul_a),
      .b    (mul_b),
      .p    (mul_p)
   );

   assign red_ctrl.start = (state_ff == ST_REDA_GO) || (state_ff == ST_REDB_GO);
   assign red_num_in = (state_ff == ST_REDB_GO) ? {{(VW-W){1'b0}}, nb_ff} : rn_ff;
   assign red_den_in = (state_ff == ST_REDB_GO) ? {{(VW-W){1'b0}}, db_ff} : rd_ff;

   fau_reduce #(
      .VALUE_WIDTH(VW)
   ) u_reduce (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (red_ctrl),
      .num    (red_num_in),
      .den    (red_den_in),
      .stat   (red_stat),
      .red_num(red_num_out),
      .red_den(red_den_out)
   );

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      na_in    = na_ff;
      da_in    = da_ff;
      nb_in    = nb_ff;
      db_in    = db_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      bn_in    = bn_ff;
      bd_in    = bd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in = fau_pkg::op_type'(req_tuser);
               na_in = req_tdata[W-1:0];
               da_in = req_tdata[2*W-1:W];
               nb_in = req_tdata[3*W-1:2*W];
               db_in = req_tdata[4*W-1:3*W];
               rn_in = {{(VW-W){1'b0}}, req_tdata[W-1:0]};
               rd_in = {{(VW-W){1'b0}}, req_tdata[2*W-1:W]};
               if (fau_pkg::op_type'(req_tuser) == fau_pkg::OP_CMP) begin
                  state_in = ST_REDA_GO;
               end else begin
                  state_in = ST_MUL0;
               end
            end
         end
         ST_MUL0: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            rn_in    = mul_p_ext;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (op_ff == fau_pkg::OP_ADD) begin
               rn_in    = rn_ff + mul_p_ext;
               state_in = ST_MUL3;
            end else begin
               rd_in    = mul_p_ext;
               state_in = ST_REDA_GO;
            end
         end
         ST_MUL3: begin
            rd_in    = mul_p_ext;
            state_in = ST_REDA_GO;
         end
         ST_REDA_GO: begin
            state_in = ST_REDA_WAIT;
         end
         ST_REDA_WAIT: begin
            if (red_stat.done) begin
               rn_in    = red_num_out;
               rd_in    = red_den_out;
               state_in = (op_ff == fau_pkg::OP_CMP) ? ST_REDB_GO : ST_OUT;
            end
         end
         ST_REDB_GO: begin
            state_in = ST_REDB_WAIT;
         end
         ST_REDB_WAIT: begin
            if (red_stat.done) begin
               bn_in    = red_num_out;
               bd_in    = red_den_out;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_eq_in    = rsp_eq_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = fau_pkg::res_num_type'(rn_ff);
         rsp_den_in   = fau_pkg::res_den_type'(rd_ff);
         rsp_eq_in    = (op_ff == fau_pkg::OP_CMP) && (rn_ff == bn_ff) && (rd_ff == bd_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      na_ff      <= na_in;
      da_ff      <= da_in;
      nb_ff      <= nb_in;
      db_ff      <= db_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_eq_ff  <= rsp_eq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_den_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_eq_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while a word is still in progress");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      red_stat.done |-> (state_ff == ST_REDA_WAIT || state_ff == ST_REDB_WAIT))
      else $error("reducer finished with no sequencer waiting");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      red_ctrl.start |-> !red_stat.busy)
      else $error("reducer started while busy");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid && !$past(state_ff == ST_IDLE))
      else $error("result register not loaded");

endmodule
